### hdl/plane_from_three_points_top_defines.svh
// Assertion macros for the plane-from-three-points checker
`ifndef PLANE_FROM_THREE_POINTS_TOP_DEFINES_SVH
`define PLANE_FROM_THREE_POINTS_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define PFT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well
`define PFT_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pft_pkg.sv
// Shared widths, types and pipeline depths for the plane-from-three-points block
package pft_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int IO_W        = 32;
  localparam int DW          = COORD_WIDTH + 1;     // edge vector component
  localparam int PW          = 2 * DW;              // edge product
  localparam int XW          = PW + 1;              // cross product component
  localparam int LW          = $clog2(XW + 1);      // bit length of a magnitude
  localparam int AW          = 31;                  // scaled magnitude
  localparam int SQW         = 2 * AW;              // square of a scaled magnitude
  localparam int SW          = 64;                  // sum of squares
  localparam int RW          = SW / 2;              // square root
  localparam int RMW         = RW + 3;              // square root remainder
  localparam int FRAC_SH     = 30;                  // Q2.30 fraction bits
  localparam int QW          = 32;                  // quotient bits
  localparam int DRW         = RW + 2;              // divider remainder
  localparam int NW          = 32;                  // normal component
  localparam int OW          = 40;                  // offset
  localparam int MW          = NW + COORD_WIDTH;    // normal times coordinate
  localparam int SUMW        = MW + 2;              // sum of three products

  localparam int CROSS_ST    = 3;
  localparam int SCALE_ST    = 5;
  localparam int SQRT_ST     = RW / 2;
  localparam int DIV_ST      = QW / 2;
  localparam int OUT_ST      = 4;
  localparam int PIPE_LAT    = CROSS_ST + SCALE_ST + SQRT_ST + DIV_ST + OUT_ST;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
    point_t     p1;
  } side_t;

  typedef logic [2:0][AW-1:0] amag_t;

endpackage

### hdl/plane_from_three_points_top.sv
// Top level of the plane-from-three-points pipeline
//
//   channel   signals                                   transfer when
//   -------   ---------------------------------------   ------------------------
//   command   start, busy, p1_x .. p3_z                 start high, busy low
//   result    done, normal_x/y/z, offset_d, degenerate  done high (one cycle)
//
// One point triple is taken every cycle while rst is low; each gives one result.
// The pipeline holds the pipelined square root and divider (16 stages each,
// two bits per stage), plus 3 cross product, 5 scaling and 4 output stages.
// busy is high only while rst is high; the synchronous reset clears every valid bit.
// The result side never stalls, so no stage ever holds: a result is shown for
// exactly one cycle under done.
module plane_from_three_points_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          p1_x,
  input  logic signed [31:0]          p1_y,
  input  logic signed [31:0]          p1_z,
  input  logic signed [31:0]          p2_x,
  input  logic signed [31:0]          p2_y,
  input  logic signed [31:0]          p2_z,
  input  logic signed [31:0]          p3_x,
  input  logic signed [31:0]          p3_y,
  input  logic signed [31:0]          p3_z,
  output logic                        done,
  output logic signed [31:0]          normal_x,
  output logic signed [31:0]          normal_y,
  output logic signed [31:0]          normal_z,
  output logic signed [39:0]          offset_d,
  output logic                        degenerate
);
  import pft_pkg::*;

  localparam int EW = ((SUMW > OW) ? SUMW : OW) + 1;
  localparam logic signed [SUMW-1:0] RND =
    {{(SUMW-FRAC_SH){1'b0}}, 1'b1, {(FRAC_SH-1){1'b0}}};
  localparam logic signed [EW-1:0] DMAX = {{(EW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [EW-1:0] DMIN = ~DMAX;

  logic   accept;
  point_t p1, p2, p3;

  logic   cr_valid;
  point_t cr_p1;
  logic signed [XW-1:0] cx, cy, cz;

  logic   sc_valid;
  side_t  sc_side;
  amag_t  sc_a;
  logic [SW-1:0] sc_sum;

  logic   sq_valid;
  logic [RW-1:0] sq_r;
  amag_t  sq_a;
  side_t  sq_side;

  logic   dv_valid;
  logic [2:0][QW-1:0] dv_q;
  side_t  dv_side;

  logic [OUT_ST-2:0] t_vld;
  logic signed [NW-1:0] n1x, n1y, n1z, n2x, n2y, n2z, n3x, n3y, n3z;
  point_t p1_t1;
  logic   dg1, dg2, dg3;
  logic signed [MW-1:0] prx, pry, prz;
  logic signed [SUMW-1:0] acc, acc_sh;
  logic signed [EW-1:0] d_ext, d_sat;

  // reset holds off commands; otherwise a triple is taken every cycle
  assign busy   = rst;
  assign accept = start & ~busy;

  assign p1.x = p1_x[COORD_WIDTH-1:0];
  assign p1.y = p1_y[COORD_WIDTH-1:0];
  assign p1.z = p1_z[COORD_WIDTH-1:0];
  assign p2.x = p2_x[COORD_WIDTH-1:0];
  assign p2.y = p2_y[COORD_WIDTH-1:0];
  assign p2.z = p2_z[COORD_WIDTH-1:0];
  assign p3.x = p3_x[COORD_WIDTH-1:0];
  assign p3.y = p3_y[COORD_WIDTH-1:0];
  assign p3.z = p3_z[COORD_WIDTH-1:0];

  pft_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .p1        (p1),
    .p2        (p2),
    .p3        (p3),
    .out_valid (cr_valid),
    .out_p1    (cr_p1),
    .cx        (cx),
    .cy        (cy),
    .cz        (cz)
  );

  pft_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cr_valid),
    .in_p1     (cr_p1),
    .cx        (cx),
    .cy        (cy),
    .cz        (cz),
    .out_valid (sc_valid),
    .out_side  (sc_side),
    .out_a     (sc_a),
    .out_sum   (sc_sum)
  );

  pft_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .in_s      (sc_sum),
    .in_a      (sc_a),
    .in_side   (sc_side),
    .out_valid (sq_valid),
    .out_r     (sq_r),
    .out_a     (sq_a),
    .out_side  (sq_side)
  );

  pft_div3 u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_r      (sq_r),
    .in_a      (sq_a),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // Round half toward plus infinity, drop 30 fraction bits, clamp to 40 bits
  always_comb begin
    acc_sh = acc >>> FRAC_SH;
    d_ext  = EW'(acc_sh);
    if (d_ext > DMAX) begin
      d_sat = DMAX;
    end else if (d_ext < DMIN) begin
      d_sat = DMIN;
    end else begin
      d_sat = d_ext;
    end
  end

  // Advance valid bits; done pulses for one cycle per result
  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= '0;
      done  <= 1'b0;
    end else begin
      t_vld <= {t_vld[OUT_ST-3:0], dv_valid};
      done  <= t_vld[OUT_ST-2];
    end
  end

  always_ff @(posedge clk) begin
    // apply signs; a degenerate triple forces a zero normal, hence zero offset
    n1x   <= dv_side.degen ? '0 : (dv_side.neg[0] ? -NW'(dv_q[0]) : NW'(dv_q[0]));
    n1y   <= dv_side.degen ? '0 : (dv_side.neg[1] ? -NW'(dv_q[1]) : NW'(dv_q[1]));
    n1z   <= dv_side.degen ? '0 : (dv_side.neg[2] ? -NW'(dv_q[2]) : NW'(dv_q[2]));
    dg1   <= dv_side.degen;
    p1_t1 <= dv_side.p1;
    // normal times first point
    prx <= n1x * p1_t1.x;
    pry <= n1y * p1_t1.y;
    prz <= n1z * p1_t1.z;
    n2x <= n1x;
    n2y <= n1y;
    n2z <= n1z;
    dg2 <= dg1;
    // exact sum with rounding bias
    acc <= SUMW'(prx) + SUMW'(pry) + SUMW'(prz) + RND;
    n3x <= n2x;
    n3y <= n2y;
    n3z <= n2z;
    dg3 <= dg2;
    // result registers
    normal_x   <= n3x;
    normal_y   <= n3y;
    normal_z   <= n3z;
    offset_d   <= d_sat[OW-1:0];
    degenerate <= dg3;
  end

endmodule

### hdl/pft_cross.sv
// Edge vectors and exact cross product, three register stages
module pft_cross (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  pft_pkg::point_t                   p1,
  input  pft_pkg::point_t                   p2,
  input  pft_pkg::point_t                   p3,
  output logic                              out_valid,
  output pft_pkg::point_t                   out_p1,
  output logic signed [pft_pkg::XW-1:0]     cx,
  output logic signed [pft_pkg::XW-1:0]     cy,
  output logic signed [pft_pkg::XW-1:0]     cz
);
  import pft_pkg::*;

  logic [CROSS_ST-1:0] vld;
  logic signed [DW-1:0] vx, vy, vz, wx, wy, wz;
  logic signed [PW-1:0] m0, m1, m2, m3, m4, m5;
  point_t p1_s1, p1_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[CROSS_ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // edge vectors
    vx <= {p1.x[COORD_WIDTH-1], p1.x} - {p2.x[COORD_WIDTH-1], p2.x};
    vy <= {p1.y[COORD_WIDTH-1], p1.y} - {p2.y[COORD_WIDTH-1], p2.y};
    vz <= {p1.z[COORD_WIDTH-1], p1.z} - {p2.z[COORD_WIDTH-1], p2.z};
    wx <= {p1.x[COORD_WIDTH-1], p1.x} - {p3.x[COORD_WIDTH-1], p3.x};
    wy <= {p1.y[COORD_WIDTH-1], p1.y} - {p3.y[COORD_WIDTH-1], p3.y};
    wz <= {p1.z[COORD_WIDTH-1], p1.z} - {p3.z[COORD_WIDTH-1], p3.z};
    p1_s1 <= p1;
    // products
    m0 <= vy * wz;
    m1 <= vz * wy;
    m2 <= vz * wx;
    m3 <= vx * wz;
    m4 <= vx * wy;
    m5 <= vy * wx;
    p1_s2 <= p1_s1;
    // differences
    cx <= {m0[PW-1], m0} - {m1[PW-1], m1};
    cy <= {m2[PW-1], m2} - {m3[PW-1], m3};
    cz <= {m4[PW-1], m4} - {m5[PW-1], m5};
    out_p1 <= p1_s2;
  end

  assign out_valid = vld[CROSS_ST-1];

endmodule

### hdl/pft_scale.sv
// Magnitudes, scaling to 31 bits and sum of squares, five register stages
module pft_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  pft_pkg::point_t                   in_p1,
  input  logic signed [pft_pkg::XW-1:0]     cx,
  input  logic signed [pft_pkg::XW-1:0]     cy,
  input  logic signed [pft_pkg::XW-1:0]     cz,
  output logic                              out_valid,
  output pft_pkg::side_t                    out_side,
  output pft_pkg::amag_t                    out_a,
  output logic [pft_pkg::SW-1:0]            out_sum
);
  import pft_pkg::*;

  function automatic logic [LW-1:0] bitlen(input logic [XW-1:0] x);
    logic [LW-1:0] n;
    n = '0;
    for (int k = 0; k < XW; k++) begin
      if (x[k]) n = LW'(k + 1);
    end
    return n;
  endfunction

  logic [SCALE_ST-1:0] vld;
  logic [2:0][XW-1:0] mag_a, mag_b;
  logic [2:0] neg_a, neg_b;
  point_t p1_a, p1_b;
  logic [LW-1:0] len_b;
  amag_t a_sh, a_c, a_d;
  side_t side_c, side_d;
  logic [2:0][SQW-1:0] sq_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SCALE_ST-2:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len_b > LW'(AW)) begin
        a_sh[i] = AW'(mag_b[i] >> (len_b - LW'(AW)));
      end else begin
        a_sh[i] = AW'(mag_b[i] << (LW'(AW) - len_b));
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_a[0] <= cx[XW-1] ? XW'(-cx) : XW'(cx);
    mag_a[1] <= cy[XW-1] ? XW'(-cy) : XW'(cy);
    mag_a[2] <= cz[XW-1] ? XW'(-cz) : XW'(cz);
    neg_a    <= {cz[XW-1], cy[XW-1], cx[XW-1]};
    p1_a     <= in_p1;
    // the OR of the magnitudes has the bit length of the largest
    len_b    <= bitlen(mag_a[0] | mag_a[1] | mag_a[2]);
    mag_b    <= mag_a;
    neg_b    <= neg_a;
    p1_b     <= p1_a;
    a_c          <= a_sh;
    side_c.degen <= (len_b == '0);
    side_c.neg   <= neg_b;
    side_c.p1    <= p1_b;
    for (int i = 0; i < 3; i++) begin
      sq_d[i] <= a_c[i] * a_c[i];
    end
    a_d      <= a_c;
    side_d   <= side_c;
    out_sum  <= SW'(sq_d[0]) + SW'(sq_d[1]) + SW'(sq_d[2]);
    out_a    <= a_d;
    out_side <= side_d;
  end

  assign out_valid = vld[SCALE_ST-1];

endmodule

### hdl/pft_isqrt.sv
// Pipelined integer square root, two result bits per stage
module pft_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [pft_pkg::SW-1:0]    in_s,
  input  pft_pkg::amag_t            in_a,
  input  pft_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [pft_pkg::RW-1:0]    out_r,
  output pft_pkg::amag_t            out_a,
  output pft_pkg::side_t            out_side
);
  import pft_pkg::*;

  logic           vld  [SQRT_ST+1];
  logic [SW-1:0]  sv   [SQRT_ST+1];
  logic [RMW-1:0] rem  [SQRT_ST+1];
  logic [RW-1:0]  root [SQRT_ST+1];
  amag_t          av   [SQRT_ST+1];
  side_t          sd   [SQRT_ST+1];

  assign vld[0]  = in_valid;
  assign sv[0]   = in_s;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign av[0]   = in_a;
  assign sd[0]   = in_side;

  for (genvar k = 0; k < SQRT_ST; k++) begin : g_st
    logic [RMW-1:0] rem_n;
    logic [RW-1:0]  root_n;
    logic [SW-1:0]  s_n;

    always_comb begin
      rem_n  = rem[k];
      root_n = root[k];
      s_n    = sv[k];
      for (int j = 0; j < 2; j++) begin
        rem_n = {rem_n[RMW-3:0], s_n[SW-1:SW-2]};
        if (rem_n >= RMW'({root_n, 2'b01})) begin
          rem_n  = rem_n - RMW'({root_n, 2'b01});
          root_n = {root_n[RW-2:0], 1'b1};
        end else begin
          root_n = {root_n[RW-2:0], 1'b0};
        end
        s_n = {s_n[SW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sv[k+1]   <= s_n;
      rem[k+1]  <= rem_n;
      root[k+1] <= root_n;
      av[k+1]   <= av[k];
      sd[k+1]   <= sd[k];
    end
  end

  assign out_valid = vld[SQRT_ST];
  assign out_r     = root[SQRT_ST];
  assign out_a     = av[SQRT_ST];
  assign out_side  = sd[SQRT_ST];

endmodule

### hdl/pft_div3.sv
// Three pipelined restoring dividers sharing one divisor, two quotient bits per stage
module pft_div3 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [pft_pkg::RW-1:0]       in_r,
  input  pft_pkg::amag_t               in_a,
  input  pft_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [2:0][pft_pkg::QW-1:0]  out_q,
  output pft_pkg::side_t               out_side
);
  import pft_pkg::*;

  localparam int NUMW = AW + FRAC_SH + 1;

  logic                vld [DIV_ST+1];
  logic [2:0][DRW-1:0] rem [DIV_ST+1];
  logic [2:0][QW-1:0]  nl  [DIV_ST+1];
  logic [2:0][QW-1:0]  q   [DIV_ST+1];
  logic [RW-1:0]       rv  [DIV_ST+1];
  side_t               sd  [DIV_ST+1];
  logic [2:0][NUMW-1:0] num;

  // numerator is a * 2^30 plus half the divisor, for round half up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]    = NUMW'({in_a[i], {FRAC_SH{1'b0}}}) + NUMW'(in_r >> 1);
      rem[0][i] = DRW'(num[i][NUMW-1:QW]);
      nl[0][i]  = num[i][QW-1:0];
      q[0][i]   = '0;
    end
  end

  assign vld[0] = in_valid;
  assign rv[0]  = in_r;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < DIV_ST; k++) begin : g_st
    logic [2:0][DRW-1:0] rem_n;
    logic [2:0][QW-1:0]  nl_n;
    logic [2:0][QW-1:0]  q_n;

    always_comb begin
      rem_n = rem[k];
      nl_n  = nl[k];
      q_n   = q[k];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          rem_n[i] = {rem_n[i][DRW-2:0], nl_n[i][QW-1]};
          nl_n[i]  = {nl_n[i][QW-2:0], 1'b0};
          if (rem_n[i] >= DRW'(rv[k])) begin
            rem_n[i] = rem_n[i] - DRW'(rv[k]);
            q_n[i]   = {q_n[i][QW-2:0], 1'b1};
          end else begin
            q_n[i]   = {q_n[i][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= rem_n;
      nl[k+1]  <= nl_n;
      q[k+1]   <= q_n;
      rv[k+1]  <= rv[k];
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = vld[DIV_ST];
  assign out_q     = q[DIV_ST];
  assign out_side  = sd[DIV_ST];

endmodule

### hdl/pft_checker.sv
// Port-level checker for the plane-from-three-points top level, with its bind
`include "plane_from_three_points_top_defines.svh"

module pft_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] normal_x,
  input logic signed [31:0] normal_y,
  input logic signed [31:0] normal_z,
  input logic signed [39:0] offset_d,
  input logic               degenerate
);
  import pft_pkg::*;

  localparam logic signed [31:0] NMAX = 32'sd1073741824;
  localparam logic signed [31:0] NMIN = -32'sd1073741824;

  `PFT_ASSERT_IMPL(a_degen_zero, clk, rst, done && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0 && offset_d == 0, "degenerate result carries nonzero fields")
  `PFT_ASSERT_IMPL(a_norm_range, clk, rst, done, normal_x <= NMAX && normal_x >= NMIN && normal_y <= NMAX && normal_y >= NMIN && normal_z <= NMAX && normal_z >= NMIN, "normal component out of range")
  `PFT_ASSERT_IMPL(a_latency, clk, rst, done, $past(start && !busy, PIPE_LAT), "result without a command at the pipeline latency")
  `PFT_ASSERT_NEXT(a_reset_quiet, clk, rst, !done, "result right after reset")

endmodule

bind plane_from_three_points_top pft_checker u_pft_checker (.*);

### tb/tb_top.sv
// Testbench for the plane-from-three-points pipeline: directed and random point triples
module tb_top;
  import pft_pkg::*;

  // One plane as the block reports it
  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [39:0] d;
    logic               degen;
  } plane_t;

  // Holds the planes still owed by the block and checks each one that comes back
  class plane_scoreboard;
    plane_t pending[$];
    int     mismatches;
    int     degen_seen;
    int     results_seen;

    // Integer square root, floor, on 64 bits
    function automatic logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s   = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Compute the plane through three points and queue it
    function void note_triple(coord_t p[3][3]);
      logic signed [127:0] v[3], w[3], c[3], mag[3], acc;
      logic [63:0]         a[3], sum, r, q;
      logic signed [63:0]  n[3];
      logic signed [127:0] dfull;
      plane_t              e;
      int                  len, l;
      for (int j = 0; j < 3; j++) begin
        v[j] = 128'(p[0][j]) - 128'(p[1][j]);
        w[j] = 128'(p[0][j]) - 128'(p[2][j]);
      end
      c[0] = v[1] * w[2] - v[2] * w[1];
      c[1] = v[2] * w[0] - v[0] * w[2];
      c[2] = v[0] * w[1] - v[1] * w[0];
      len = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = c[i] < 0 ? -c[i] : c[i];
        l = 0;
        for (int b = 0; b < 128; b++) if (mag[i][b]) l = b + 1;
        if (l > len) len = l;
      end
      if (len == 0) begin
        e = '{nx: 0, ny: 0, nz: 0, d: 0, degen: 1'b1};
        pending.insert(pending.size(), e);
        return;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        if (len > 31) a[i] = 64'(mag[i] >> (len - 31));
        else a[i] = 64'(mag[i] << (31 - len));
        sum = sum + a[i] * a[i];
      end
      r = root_floor(sum);
      acc = 128'sd1 << 29;
      for (int i = 0; i < 3; i++) begin
        q = ((a[i] << 30) + (r >> 1)) / r;
        n[i] = c[i] < 0 ? -$signed(q) : $signed(q);
        acc = acc + 128'(n[i]) * 128'(p[0][i]);
      end
      dfull = acc >>> 30;
      // clamp to the 40-bit offset range
      if (dfull > 128'sd549755813887) dfull = 128'sd549755813887;
      if (dfull < -128'sd549755813888) dfull = -128'sd549755813888;
      e.nx = n[0][31:0];
      e.ny = n[1][31:0];
      e.nz = n[2][31:0];
      e.d  = dfull[39:0];
      e.degen = 1'b0;
      pending.insert(pending.size(), e);
    endfunction

    // Compare one reported plane with the oldest one owed
    function void check_plane(plane_t got);
      plane_t e;
      results_seen++;
      if (got.degen) degen_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d d=%0d degen=%0b",
                 $time, got.nx, got.ny, got.nz, got.d, got.degen);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (got.nx !== e.nx) begin
        $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, got.nx);
        mismatches++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, got.ny);
        mismatches++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: normal_z expected %0d actual %0d", $time, e.nz, got.nz);
        mismatches++;
      end
      if (got.d !== e.d) begin
        $display("%0t: offset_d expected %0d actual %0d", $time, e.d, got.d);
        mismatches++;
      end
      if (got.degen !== e.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, got.degen);
        mismatches++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, degenerate;
  logic signed [31:0] p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z;
  logic signed [31:0] normal_x, normal_y, normal_z;
  logic signed [39:0] offset_d;

  plane_scoreboard planes = new();
  int triples_sent;
  bit free_run;  // when set the sender never idles

  plane_from_three_points_top DUT (
    .clk, .rst, .start, .busy,
    .p1_x, .p1_y, .p1_z, .p2_x, .p2_y, .p2_z, .p3_x, .p3_y, .p3_z,
    .done, .normal_x, .normal_y, .normal_z, .offset_d, .degenerate
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watch both channels at the clock edge; inputs are only changed by NBAs at
  // the same edge, so the values seen here are the ones the block took.
  always @(posedge clk) begin
    coord_t pts[3][3];
    plane_t got;
    if (!rst && start && !busy) begin
      pts = '{'{p1_x, p1_y, p1_z}, '{p2_x, p2_y, p2_z}, '{p3_x, p3_y, p3_z}};
      planes.note_triple(pts);
      triples_sent++;
    end
    if (!rst && done) begin
      got = '{nx: normal_x, ny: normal_y, nz: normal_z, d: offset_d, degen: degenerate};
      planes.check_plane(got);
    end
  end

  // Present one triple and hold it until the block takes the transfer.
  // busy only moves at the rising edge, so its value at the falling edge
  // is the one the next rising edge sees.
  task automatic send_triple(coord_t ax, ay, az, bx, by, bz, cx, cy, cz);
    start <= 1'b1;
    p1_x <= ax; p1_y <= ay; p1_z <= az;
    p2_x <= bx; p2_y <= by; p2_z <= bz;
    p3_x <= cx; p3_y <= cy; p3_z <= cz;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop start for a random number of cycles, each cycle idle about a quarter of the time
  task automatic maybe_idle();
    if (!free_run) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  function automatic coord_t rnd_full();
    return coord_t'($urandom);
  endfunction

  // Coordinates within -2^19 .. 2^19-1, so most triples give well-shaped planes
  function automatic coord_t rnd_near();
    return coord_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
  endfunction

  // Random triple, mostly well-formed planes, some collinear, coincident or with tiny edges
  task automatic send_random();
    coord_t a[3], b[3], c[3];
    int kind, k;
    kind = $urandom_range(99);
    for (int j = 0; j < 3; j++) begin
      a[j] = (kind < 30) ? rnd_full() : rnd_near();
      b[j] = (kind < 30) ? rnd_full() : rnd_near();
      c[j] = (kind < 30) ? rnd_full() : rnd_near();
    end
    if (kind >= 85 && kind < 93) begin
      // collinear: third point along the first edge
      k = $urandom_range(0, 6) - 3;
      for (int j = 0; j < 3; j++) begin
        a[j] = $signed(a[j]) >>> 4;
        b[j] = $signed(b[j]) >>> 4;
        c[j] = a[j] + k * (b[j] - a[j]);
      end
    end else if (kind >= 93 && kind < 97) begin
      // two or three points coincide
      b = a;
      if (kind == 96) c = a;
    end else if (kind >= 97) begin
      // tiny edges: cross product of only a few bits
      for (int j = 0; j < 3; j++) begin
        b[j] = a[j] + $signed($urandom_range(0, 2)) - 1;
        c[j] = a[j] + $signed($urandom_range(0, 2)) - 1;
      end
    end
    send_triple(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
  endtask

  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam coord_t ONE  = 32'sh0001_0000;

  initial begin
    int t0;
    rst = 1'b1; start = 1'b0; free_run = 1'b0;
    {p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zeros, coincident, collinear, axis planes, extremes
    send_triple(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_triple(ONE, ONE, ONE, ONE, ONE, ONE, -ONE, 5, 7);
    send_triple(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);
    send_triple(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE);
    maybe_idle();
    send_triple(0, 0, ONE, 0, ONE, ONE, ONE, 0, ONE);
    send_triple(ONE, 0, 0, ONE, ONE, 0, ONE, 0, ONE);
    send_triple(0, -ONE, 0, ONE, -ONE, 0, 0, -ONE, ONE);
    send_triple(0, 0, CMAX, ONE, 0, CMAX, 0, ONE, CMAX);
    send_triple(0, 0, CMIN, 0, ONE, CMIN, ONE, 0, CMIN);
    send_triple(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX);
    send_triple(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX);
    send_triple(CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX);
    send_triple(CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN);
    send_triple(-1, -1, -1, 0, 0, 0, 1, 0, 0);
    send_triple(1, 2, 3, 2, 3, 5, 4, 1, 3);
    send_triple(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_triple(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0);

    // Random: a burst with no gaps in the middle of the run
    for (int i = 0; i < 550; i++) begin
      free_run = (i >= 200 && i < 300);
      maybe_idle();
      send_random();
    end
    start <= 1'b0;

    // Drain the pipeline, then give it the latency once more
    t0 = 0;
    while (planes.pending.size() != 0 && t0 < 1000) begin
      @(posedge clk);
      t0++;
    end
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (planes.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, planes.pending.size());
      planes.mismatches++;
    end

    $display("Sent %0d point triples, checked %0d planes (%0d degenerate).",
             triples_sent, planes.results_seen, planes.degen_seen);
    if (planes.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #400000;
    $display("Timeout after %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule
